// ----- rtl/core/door_vibration_alarm_controller_defines.svh -----
// Assertion macros shared by the RTL of the door and vibration alarm controller.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef DOOR_VIBRATION_ALARM_CONTROLLER_DEFINES_SVH
`define DOOR_VIBRATION_ALARM_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DVA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dva same-cycle check failed");

// Next-cycle implication, checked outside reset
`define DVA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dva next-cycle check failed");

`endif

// ----- rtl/core/dva_pkg.sv -----
`timescale 1ns / 1ps

package dva_pkg;

    // Command codes
    localparam logic [2:0] CMD_HALL    = 3'd0;
    localparam logic [2:0] CMD_VIB     = 3'd1;
    localparam logic [2:0] CMD_ARM     = 3'd2;
    localparam logic [2:0] CMD_DISARM  = 3'd3;
    localparam logic [2:0] CMD_RESET   = 3'd4;
    localparam logic [2:0] CMD_TICK    = 3'd5;

    // Magnet sensor actions
    localparam logic [1:0] HALL_CLOSE  = 2'd1;
    localparam logic [1:0] HALL_AWAY   = 2'd2;

    // Door states
    localparam logic [1:0] DOOR_UNKNOWN = 2'd0;
    localparam logic [1:0] DOOR_CLOSED  = 2'd1;
    localparam logic [1:0] DOOR_OPEN    = 2'd2;

    // Guard modes
    localparam logic [1:0] MODE_DISARMED = 2'd0;
    localparam logic [1:0] MODE_ARMED    = 2'd1;
    localparam logic [1:0] MODE_ALARM    = 2'd2;

    // Cause flags
    localparam logic [1:0] CAUSE_DOOR = 2'b01;
    localparam logic [1:0] CAUSE_VIB  = 2'b10;

    // LED bits
    localparam logic [4:0] LED_CLOSED = 5'h01;
    localparam logic [4:0] LED_OPEN   = 5'h02;
    localparam logic [4:0] LED_VIB    = 5'h04;
    localparam logic [4:0] LED_GUARD  = 5'h08;
    localparam logic [4:0] LED_ALERT  = 5'h10;

    typedef struct packed {
        logic [2:0] command;
        logic [1:0] hall_event;
        logic       quake_seen;
        logic       beeper_free;
    } item_t;

    typedef struct packed {
        logic [1:0] door_status;
        logic       door_moved;
        logic       quake_pending;
        logic [7:0] quake_counter;
        logic [1:0] guard_state;
        logic [1:0] cause_flags;
        logic       beep_owed;
    } state_t;

    typedef struct packed {
        logic       command_ok;
        logic [4:0] led_pattern;
        logic       beep_start;
        logic [1:0] guard_mode;
        logic [1:0] door_now;
        logic [1:0] alarm_cause;
        logic [7:0] quake_total;
    } result_t;

endpackage

// ----- rtl/core/dva_step.sv -----
`timescale 1ns / 1ps

// Single-pass update: one word against the current state gives the next
// state and the result word.
module dva_step (
    input  dva_pkg::item_t   item,
    input  dva_pkg::state_t  state_cur,
    output dva_pkg::state_t  state_next,
    output dva_pkg::result_t result
);

    always_comb
    begin
        logic [1:0] door_new;
        logic       ok;
        logic [4:0] leds;
        logic       beep;
        dva_pkg::state_t st;

        st       = state_cur;
        ok       = 1'b1;
        leds     = 5'd0;
        beep     = 1'b0;
        door_new = state_cur.door_status;

        case (item.command)
            dva_pkg::CMD_HALL:
            begin
                if (item.hall_event == dva_pkg::HALL_CLOSE)
                begin
                    door_new = dva_pkg::DOOR_CLOSED;
                end
                else if (item.hall_event == dva_pkg::HALL_AWAY)
                begin
                    door_new = dva_pkg::DOOR_OPEN;
                end
                if (door_new != state_cur.door_status)
                begin
                    st.door_status = door_new;
                    st.door_moved  = 1'b1;
                end
            end
            dva_pkg::CMD_VIB:
            begin
                if (item.quake_seen)
                begin
                    st.quake_pending = 1'b1;
                    st.quake_counter = state_cur.quake_counter + 8'd1;
                end
            end
            dva_pkg::CMD_ARM, dva_pkg::CMD_RESET:
            begin
                // arm needs no alarm; reset-alarm needs the alarm; both need a closed door
                if (((item.command == dva_pkg::CMD_ARM)
                        == (state_cur.guard_state == dva_pkg::MODE_ALARM))
                    || state_cur.door_status != dva_pkg::DOOR_CLOSED)
                begin
                    ok = 1'b0;
                end
                else
                begin
                    st.guard_state   = dva_pkg::MODE_ARMED;
                    st.cause_flags   = 2'b00;
                    st.beep_owed     = 1'b0;
                    st.door_moved    = 1'b0;
                    st.quake_pending = 1'b0;
                end
            end
            dva_pkg::CMD_DISARM:
            begin
                st.guard_state   = dva_pkg::MODE_DISARMED;
                st.cause_flags   = 2'b00;
                st.beep_owed     = 1'b0;
                st.door_moved    = 1'b0;
                st.quake_pending = 1'b0;
            end
            dva_pkg::CMD_TICK:
            begin
                if (state_cur.door_status == dva_pkg::DOOR_CLOSED)
                begin
                    leds = leds | dva_pkg::LED_CLOSED;
                end
                else if (state_cur.door_status == dva_pkg::DOOR_OPEN)
                begin
                    leds = leds | dva_pkg::LED_OPEN;
                end

                // raise alarm on door opening or pending vibration while guarding
                if (state_cur.guard_state != dva_pkg::MODE_DISARMED)
                begin
                    if (state_cur.door_moved
                        && state_cur.door_status == dva_pkg::DOOR_OPEN)
                    begin
                        if (st.guard_state != dva_pkg::MODE_ALARM)
                        begin
                            st.guard_state = dva_pkg::MODE_ALARM;
                            st.beep_owed   = 1'b1;
                        end
                        st.cause_flags = st.cause_flags | dva_pkg::CAUSE_DOOR;
                    end
                    if (state_cur.quake_pending)
                    begin
                        if (st.guard_state != dva_pkg::MODE_ALARM)
                        begin
                            st.guard_state = dva_pkg::MODE_ALARM;
                            st.beep_owed   = 1'b1;
                        end
                        st.cause_flags = st.cause_flags | dva_pkg::CAUSE_VIB;
                    end
                end
                st.door_moved    = 1'b0;
                st.quake_pending = 1'b0;

                // one beep per alarm, when the beeper can take it
                if (st.guard_state == dva_pkg::MODE_ALARM && st.beep_owed
                    && item.beeper_free)
                begin
                    beep         = 1'b1;
                    st.beep_owed = 1'b0;
                end

                if ((st.cause_flags & dva_pkg::CAUSE_VIB) != 2'b00)
                begin
                    leds = leds | dva_pkg::LED_VIB;
                end
                if (st.guard_state == dva_pkg::MODE_ARMED)
                begin
                    leds = leds | dva_pkg::LED_GUARD;
                end
                else if (st.guard_state == dva_pkg::MODE_ALARM)
                begin
                    leds = leds | dva_pkg::LED_ALERT;
                end
            end
            default:
            begin
                // unused codes change nothing
            end
        endcase

        state_next         = st;
        result.command_ok  = ok;
        result.led_pattern = leds;
        result.beep_start  = beep;
        result.guard_mode  = st.guard_state;
        result.door_now    = st.door_status;
        result.alarm_cause = st.cause_flags;
        result.quake_total = st.quake_counter;
    end

endmodule

// ----- rtl/core/door_vibration_alarm_controller.sv -----
// Door and vibration alarm controller. Each input word carries one command
// (hall event, vibration event, arm, disarm, reset alarm, tick) and yields
// exactly one result word with the command status, the LED pattern and beep
// request on a tick, and the guard, door, cause and vibration-count state after
// the command. A word is taken every clock cycle when the output side keeps up;
// each word passes through the input register and then the result register,
// and the state update for a word is done combinationally between them.
// Both channels are valid/ready; the block holds at most two words.
`timescale 1ns / 1ps
`include "door_vibration_alarm_controller_defines.svh"

module door_vibration_alarm_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [1:0] hall_event,
    input  logic       quake_seen,
    input  logic       beeper_free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       command_ok,
    output logic [4:0] led_pattern,
    output logic       beep_start,
    output logic [1:0] guard_mode,
    output logic [1:0] door_now,
    output logic [1:0] alarm_cause,
    output logic [7:0] quake_total
);

    logic             item_valid_reg;
    dva_pkg::item_t   item_reg;
    logic             out_valid_reg;
    dva_pkg::result_t result_reg;
    dva_pkg::result_t result_next;
    dva_pkg::state_t  state_reg;
    dva_pkg::state_t  state_next;
    logic             advance;

    // Word moves from input register to result register
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command     <= command;
            item_reg.hall_event  <= hall_event;
            item_reg.quake_seen  <= quake_seen;
            item_reg.beeper_free <= beeper_free;
        end
    end

    dva_step u_step (
        .item       (item_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.door_status   <= dva_pkg::DOOR_UNKNOWN;
            state_reg.door_moved    <= 1'b0;
            state_reg.quake_pending <= 1'b0;
            state_reg.quake_counter <= 8'd0;
            state_reg.guard_state   <= dva_pkg::MODE_DISARMED;
            state_reg.cause_flags   <= 2'b00;
            state_reg.beep_owed     <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign command_ok  = result_reg.command_ok;
    assign led_pattern = result_reg.led_pattern;
    assign beep_start  = result_reg.beep_start;
    assign guard_mode  = result_reg.guard_mode;
    assign door_now    = result_reg.door_now;
    assign alarm_cause = result_reg.alarm_cause;
    assign quake_total = result_reg.quake_total;

    // Checks
    `DVA_ASSERT_NOW(a_beep_only_in_alarm, out_valid_reg && result_reg.beep_start, result_reg.guard_mode == dva_pkg::MODE_ALARM)
    `DVA_ASSERT_NOW(a_alarm_led_matches_mode, out_valid_reg && result_reg.led_pattern[4], result_reg.guard_mode == dva_pkg::MODE_ALARM)
    `DVA_ASSERT_NOW(a_full_stall_blocks_input, item_valid_reg && out_valid_reg && !out_ready, !in_ready)
    `DVA_ASSERT_NEXT(a_counter_steps_by_one, advance, (state_reg.quake_counter == $past(state_reg.quake_counter)) || (state_reg.quake_counter == $past(state_reg.quake_counter) + 8'd1))

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no word moving on either side
    localparam int RANDOM_WORDS  = 1000;
    localparam int LONG_HOLD     = 60;    // receiver back-pressure stretch
    localparam int DRAIN_CYCLES  = 8;

    // Tracks the alarm state and the result words still owed by the block
    class alarm_scoreboard;
        logic [1:0] door;
        logic       door_mark;
        logic       quake_flag;
        logic [7:0] quake_count;
        logic [1:0] guard;
        logic [1:0] causes;
        logic       beep_due;
        bit         count_wrapped;
        int         errors;
        dva_pkg::result_t owed[$];

        function new();
            door          = dva_pkg::DOOR_UNKNOWN;
            door_mark     = 1'b0;
            quake_flag    = 1'b0;
            quake_count   = 8'd0;
            guard         = dva_pkg::MODE_DISARMED;
            causes        = 2'b00;
            beep_due      = 1'b0;
            count_wrapped = 0;
            errors        = 0;
        endfunction

        function void clear_marks();
            causes     = 2'b00;
            beep_due   = 1'b0;
            door_mark  = 1'b0;
            quake_flag = 1'b0;
        endfunction

        function void raise_alarm(logic [1:0] cause);
            if (guard != dva_pkg::MODE_ALARM)
            begin
                guard    = dva_pkg::MODE_ALARM;
                beep_due = 1'b1;
            end
            causes = causes | cause;
        endfunction

        // Predict the result for one accepted command word
        function void note_command(dva_pkg::item_t w);
            dva_pkg::result_t r;
            logic [1:0]       next_door;
            r            = '0;
            r.command_ok = 1'b1;
            case (w.command)
                dva_pkg::CMD_HALL:
                begin
                    next_door = door;
                    if (w.hall_event == dva_pkg::HALL_CLOSE)
                        next_door = dva_pkg::DOOR_CLOSED;
                    else if (w.hall_event == dva_pkg::HALL_AWAY)
                        next_door = dva_pkg::DOOR_OPEN;
                    if (next_door != door)
                    begin
                        door      = next_door;
                        door_mark = 1'b1;
                    end
                end
                dva_pkg::CMD_VIB:
                begin
                    if (w.quake_seen)
                    begin
                        quake_flag  = 1'b1;
                        quake_count = quake_count + 8'd1;
                        if (quake_count == 8'd0)
                            count_wrapped = 1;
                    end
                end
                dva_pkg::CMD_ARM:
                begin
                    if (guard == dva_pkg::MODE_ALARM || door != dva_pkg::DOOR_CLOSED)
                        r.command_ok = 1'b0;
                    else
                    begin
                        guard = dva_pkg::MODE_ARMED;
                        clear_marks();
                    end
                end
                dva_pkg::CMD_DISARM:
                begin
                    guard = dva_pkg::MODE_DISARMED;
                    clear_marks();
                end
                dva_pkg::CMD_RESET:
                begin
                    if (guard != dva_pkg::MODE_ALARM || door != dva_pkg::DOOR_CLOSED)
                        r.command_ok = 1'b0;
                    else
                    begin
                        guard = dva_pkg::MODE_ARMED;
                        clear_marks();
                    end
                end
                dva_pkg::CMD_TICK:
                begin
                    if (door == dva_pkg::DOOR_CLOSED)
                        r.led_pattern |= dva_pkg::LED_CLOSED;
                    else if (door == dva_pkg::DOOR_OPEN)
                        r.led_pattern |= dva_pkg::LED_OPEN;
                    // disarmed: pending door and vibration marks are dropped
                    if (guard == dva_pkg::MODE_DISARMED)
                    begin
                        door_mark  = 1'b0;
                        quake_flag = 1'b0;
                    end
                    else
                    begin
                        if (door_mark)
                        begin
                            if (door == dva_pkg::DOOR_OPEN)
                                raise_alarm(dva_pkg::CAUSE_DOOR);
                            door_mark = 1'b0;
                        end
                        if (quake_flag)
                        begin
                            raise_alarm(dva_pkg::CAUSE_VIB);
                            quake_flag = 1'b0;
                        end
                    end
                    if (guard == dva_pkg::MODE_ALARM && beep_due && w.beeper_free)
                    begin
                        r.beep_start = 1'b1;
                        beep_due     = 1'b0;
                    end
                    if ((causes & dva_pkg::CAUSE_VIB) != 2'b00)
                        r.led_pattern |= dva_pkg::LED_VIB;
                    if (guard == dva_pkg::MODE_ARMED)
                        r.led_pattern |= dva_pkg::LED_GUARD;
                    else if (guard == dva_pkg::MODE_ALARM)
                        r.led_pattern |= dva_pkg::LED_ALERT;
                end
                default: ;  // unused codes leave the state alone
            endcase
            r.guard_mode  = guard;
            r.door_now    = door;
            r.alarm_cause = causes;
            r.quake_total = quake_count;
            owed.push_back(r);
        endfunction

        function void check_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result word against the oldest prediction
        function void check_result(dva_pkg::result_t got);
            dva_pkg::result_t want;
            if (owed.size() == 0)
            begin
                $error("result word arrived with nothing outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            check_field("command_ok", 8'(want.command_ok), 8'(got.command_ok));
            check_field("led_pattern", 8'(want.led_pattern), 8'(got.led_pattern));
            check_field("beep_start", 8'(want.beep_start), 8'(got.beep_start));
            check_field("guard_mode", 8'(want.guard_mode), 8'(got.guard_mode));
            check_field("door_now", 8'(want.door_now), 8'(got.door_now));
            check_field("alarm_cause", 8'(want.alarm_cause), 8'(got.alarm_cause));
            check_field("quake_total", want.quake_total, got.quake_total);
        endfunction

        function int outstanding();
            return owed.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] command;
    logic [1:0] hall_event;
    logic       quake_seen;
    logic       beeper_free;
    logic       out_valid;
    logic       out_ready;
    logic       command_ok;
    logic [4:0] led_pattern;
    logic       beep_start;
    logic [1:0] guard_mode;
    logic [1:0] door_now;
    logic [1:0] alarm_cause;
    logic [7:0] quake_total;

    alarm_scoreboard sb;
    int words_sent;
    int idle_cycles;

    door_vibration_alarm_controller uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .hall_event  (hall_event),
        .quake_seen  (quake_seen),
        .beeper_free (beeper_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .command_ok  (command_ok),
        .led_pattern (led_pattern),
        .beep_start  (beep_start),
        .guard_mode  (guard_mode),
        .door_now    (door_now),
        .alarm_cause (alarm_cause),
        .quake_total (quake_total)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Monitor: results are checked before the same edge's input is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result(dva_pkg::result_t'({command_ok, led_pattern,
                                                    beep_start, guard_mode,
                                                    door_now, alarm_cause,
                                                    quake_total}));
            if (in_valid && in_ready)
                sb.note_command(dva_pkg::item_t'({command, hall_event, quake_seen,
                                                  beeper_free}));
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // Offer one command word; called and returns at a falling edge
    task automatic send_word(dva_pkg::item_t w);
        int  gap;
        bit  calm;
        calm = ((words_sent / 50) % 5) == 4;
        gap  = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {command, hall_event, quake_seen, beeper_free} <= w;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        words_sent++;
        @(negedge clk);
    endtask

    function automatic dva_pkg::item_t make_word(logic [2:0] c, logic [1:0] h,
                                                 logic q, logic f);
        dva_pkg::item_t w;
        w.command     = c;
        w.hall_event  = h;
        w.quake_seen  = q;
        w.beeper_free = f;
        return w;
    endfunction

    function automatic dva_pkg::item_t any_word();
        return dva_pkg::item_t'($urandom_range(0, 127));
    endfunction

    // Sensor and timer traffic typical of a guarded door
    function automatic dva_pkg::item_t scene_word();
        dva_pkg::item_t w;
        int             pick;
        w    = any_word();
        pick = $urandom_range(0, 19);
        if (pick < 5)
            w.command = dva_pkg::CMD_HALL;
        else if (pick < 10)
        begin
            w.command    = dva_pkg::CMD_VIB;
            w.quake_seen = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 17)
            w.command = dva_pkg::CMD_TICK;
        else if (pick == 17)
            w.command = dva_pkg::CMD_RESET;
        else if (pick == 18)
            w.command = dva_pkg::CMD_ARM;
        else
            w.command = dva_pkg::CMD_DISARM;
        return w;
    endfunction

    task automatic random_sequence();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            // close the door, arm, then live traffic and maybe clear the alarm
            send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_CLOSE, 1'($urandom),
                                1'($urandom)));
            send_word(make_word(dva_pkg::CMD_ARM, 2'($urandom), 1'($urandom),
                                1'($urandom)));
            n = $urandom_range(2, 10);
            repeat (n) send_word(scene_word());
            if ($urandom_range(0, 1))
            begin
                send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_CLOSE,
                                    1'($urandom), 1'($urandom)));
                send_word(make_word(dva_pkg::CMD_RESET, 2'($urandom), 1'($urandom),
                                    1'($urandom)));
                send_word(make_word(dva_pkg::CMD_TICK, 2'($urandom), 1'($urandom),
                                    1'($urandom)));
            end
        end
        else if (kind == 4)
        begin
            // burst of vibration reports, pushes the counter around
            n = $urandom_range(8, 32);
            repeat (n)
                send_word(make_word(dva_pkg::CMD_VIB, 2'($urandom),
                                    ($urandom_range(0, 7) != 0), 1'($urandom)));
        end
        else if (kind <= 6)
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_word(any_word());
        end
        else
        begin
            n = $urandom_range(3, 12);
            repeat (n) send_word(scene_word());
        end
    endtask

    // Receiver: random stalls, calm stretches and two long holds
    initial
    begin
        int taken;
        int stall;
        bit calm;
        taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            calm = ((taken / 64) % 4) == 3;
            if (taken == 200 || taken == 600)
                stall = LONG_HOLD;
            else
                stall = calm ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            taken++;
            @(negedge clk);
        end
    end

    // Reset, directed words, random words, drain and verdict
    initial
    begin
        int directed;
        sb          = new();
        words_sent  = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        out_ready   = 1'b0;
        command     = dva_pkg::CMD_HALL;
        hall_event  = 2'b00;
        quake_seen  = 1'b0;
        beeper_free = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // door unknown: tick shows nothing, arm and reset refused
        send_word(make_word(dva_pkg::CMD_TICK, 2'd0, 1'b0, 1'b1));
        send_word(make_word(dva_pkg::CMD_ARM, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_RESET, 2'd0, 1'b0, 1'b0));
        // hall codes with no action
        send_word(make_word(dva_pkg::CMD_HALL, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_HALL, 2'd3, 1'b1, 1'b1));
        // door open: arm refused
        send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_AWAY, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_TICK, 2'd0, 1'b0, 1'b1));
        send_word(make_word(dva_pkg::CMD_ARM, 2'd0, 1'b0, 1'b0));
        // same door state twice, quiet vibration, tick while disarmed drops marks
        send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_CLOSE, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_CLOSE, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_VIB, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_VIB, 2'd0, 1'b1, 1'b0));
        send_word(make_word(dva_pkg::CMD_TICK, 2'd0, 1'b0, 1'b1));
        // arm, arm again while armed
        send_word(make_word(dva_pkg::CMD_ARM, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_ARM, 2'd3, 1'b1, 1'b1));
        // both causes, beeper busy then free
        send_word(make_word(dva_pkg::CMD_VIB, 2'd0, 1'b1, 1'b0));
        send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_AWAY, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_TICK, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_TICK, 2'd0, 1'b0, 1'b1));
        // reset refused with door open, arm refused in alarm, then reset ok
        send_word(make_word(dva_pkg::CMD_RESET, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_ARM, 2'd0, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_HALL, dva_pkg::HALL_CLOSE, 1'b0, 1'b0));
        send_word(make_word(dva_pkg::CMD_RESET, 2'd0, 1'b0, 1'b0));
        // unused command codes
        send_word(make_word(3'd6, 2'd3, 1'b1, 1'b1));
        send_word(make_word(3'd7, 2'd3, 1'b1, 1'b1));
        send_word(make_word(dva_pkg::CMD_DISARM, 2'd0, 1'b0, 1'b0));
        directed = words_sent;

        while (words_sent < directed + RANDOM_WORDS || !sb.count_wrapped)
            random_sequence();
        in_valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.outstanding() != 0)
        begin
            $error("%0d result words never arrived", sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dva_pkg.sv
rtl/core/dva_step.sv
rtl/core/door_vibration_alarm_controller.sv
verif/testbench.sv
